/* hw/rtl/mhs_pkg.sv */
// ---------------------------------------------------------------------------
// mhs_pkg
// shared constants and helpers for the minhash n-gram signature block
// ---------------------------------------------------------------------------
package mhs_pkg;

    localparam int TOKEN_W    = 32;
    localparam int VALUE_W    = 64;
    localparam int SLOT_IDX_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // murmur mixing constants
    localparam logic [VALUE_W-1:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int                 MIX_SHIFT = 47;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASHES_USED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NGRAM_LEN   = 2'd2;

    // reset values of the configuration registers
    localparam logic [31:0] HASH_SEED_RST   = 32'd0;
    localparam logic [6:0]  HASHES_USED_RST = 7'd64;
    localparam logic [3:0]  NGRAM_LEN_RST   = 4'd3;

    // x ^ (x >> r)
    function automatic logic [VALUE_W-1:0] xor_shift(input logic [VALUE_W-1:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

/* hw/rtl/mhs_token_if.sv */
// ---------------------------------------------------------------------------
// mhs_token_if
// token input channel: valid/ready with token, first and final_req
// ---------------------------------------------------------------------------
interface mhs_token_if;
    logic        valid;
    logic        ready;
    logic [31:0] token;
    logic        first;
    logic        final_req;

    modport source (output valid, output token, output first, output final_req,
                    input ready);
    modport sink   (input valid, input token, input first, input final_req,
                    output ready);
endinterface

/* hw/rtl/mhs_slot_if.sv */
// ---------------------------------------------------------------------------
// mhs_slot_if
// signature readout channel: valid/ready with one slot per transaction
// ---------------------------------------------------------------------------
interface mhs_slot_if;
    logic        valid;
    logic        ready;
    logic [5:0]  slot_index;
    logic [63:0] slot_value;
    logic        end_of_run;
    logic        status;

    modport source (output valid, output slot_index, output slot_value,
                    output end_of_run, output status, input ready);
    modport sink   (input valid, input slot_index, input slot_value,
                    input end_of_run, input status, output ready);
endinterface

/* hw/rtl/mhs_ram.sv */
// ---------------------------------------------------------------------------
// mhs_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module mhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/mhs_mul.sv */
// ---------------------------------------------------------------------------
// mhs_mul
// 64-bit multiply by the mixing constant, modulo 2^64, on one 32x32 multiplier
// ---------------------------------------------------------------------------
module mhs_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [mhs_pkg::VALUE_W-1:0] operand,
    output logic                   done,
    output logic [mhs_pkg::VALUE_W-1:0] product
);

    import mhs_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOLO = 2'd1;
    localparam logic [1:0] PH_LOHI = 2'd2;
    localparam logic [1:0] PH_HILO = 2'd3;

    localparam logic [31:0] M_LO = MIX_MUL[31:0];
    localparam logic [31:0] M_HI = MIX_MUL[63:32];

    logic [1:0]         phase_reg;
    logic               done_reg;
    logic [VALUE_W-1:0] x_reg;
    logic [VALUE_W-1:0] acc_reg;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;

    // one shared multiplier, operands picked by phase
    always_comb
    begin
        mul_a = x_reg[31:0];
        mul_b = M_LO;
        case (phase_reg)
            PH_LOHI: mul_b = M_HI;
            PH_HILO: mul_a = x_reg[63:32];
            default: ;
        endcase
    end

    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                phase_reg <= PH_LOLO;
            end
            else
            begin
                case (phase_reg)
                    PH_LOLO: phase_reg <= PH_LOHI;
                    PH_LOHI: phase_reg <= PH_HILO;
                    PH_HILO:
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                    default: phase_reg <= PH_IDLE;
                endcase
            end
        end
    end

    // cross products only reach the upper word
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= operand;
        end
        case (phase_reg)
            PH_LOLO: acc_reg <= mul_p;
            PH_LOHI,
            PH_HILO: acc_reg[63:32] <= acc_reg[63:32] + mul_p[31:0];
            default: ;
        endcase
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* hw/rtl/minhash_ngram_signature_top.sv */
// ---------------------------------------------------------------------------
// minhash_ngram_signature_top
// minhash signature over token n-grams, murmur 64-bit hash per slot
// ---------------------------------------------------------------------------
// usage
//   token_ch carries one token per transaction with first and final_req flags.
//   first clears the window count and the signature before the token is used.
//   once ngram_len tokens are held, every token hashes the newest n-gram once
//   per slot (seed hash_seed + slot) and each slot keeps the smaller value.
//   final_req makes the block read out hashes_used slots on slot_ch, slot 0
//   first, end_of_run on the last, status 1 when the document was too short.
// sequencing
//   all mixing runs on one 32x32 multiplier, three passes per 64-bit multiply,
//   and a token that completes an n-gram holds token_ch at least until all
//   hashes_used slots are hashed. a token that completes no n-gram is taken
//   without holding token_ch. readout moves each slot through an address
//   state and a load state, and a stalled slot_ch holds the load state.
// reset and stall
//   reset clears the signature valid flags so every slot reads as all ones,
//   and loads the register defaults (seed 0, 64 slots, n-grams of 3).
//   slot_ch has an output register: a stalled receiver holds the readout, and
//   after the last slot is loaded the block takes new tokens while it waits.
//   configuration writes are taken at any edge with cfg_wr_en high.
// ---------------------------------------------------------------------------
module minhash_ngram_signature_top #(
    parameter int NUM_SLOTS = 64,
    parameter int MAX_NGRAM = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mhs_token_if.sink                     token_ch,
    mhs_slot_if.source                    slot_ch,
    input  logic                          cfg_wr_en,
    input  logic [mhs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mhs_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mhs_pkg::*;

    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int NG_W       = $clog2(MAX_NGRAM + 1);
    localparam int WIN_W      = TOKEN_W * MAX_NGRAM;
    localparam int WORK_W     = TOKEN_W * (MAX_NGRAM + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SLOT     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_MUL_K1   = 4'd3;
    localparam logic [3:0] S_MUL_K2   = 4'd4;
    localparam logic [3:0] S_MUL_HP   = 4'd5;
    localparam logic [3:0] S_MUL_HT   = 4'd6;
    localparam logic [3:0] S_MUL_F    = 4'd7;
    localparam logic [3:0] S_UPDATE   = 4'd8;
    localparam logic [3:0] S_RD_ADDR  = 4'd9;
    localparam logic [3:0] S_RD_LOAD  = 4'd10;

    // configuration
    logic [31:0] hash_seed_reg;
    logic [6:0]  hashes_used_reg;
    logic [3:0]  ngram_len_reg;

    // control
    logic [3:0]           state_reg;
    logic [NG_W-1:0]      tokens_seen_reg;
    logic                 final_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [NG_W-1:0]      pair_cnt_reg;
    logic [NUM_SLOTS-1:0] valid_reg;

    // datapath
    logic [WIN_W-1:0]   window_reg;
    logic [WIN_W-1:0]   shingle_reg;
    logic [WORK_W-1:0]  work_reg;
    logic [VALUE_W-1:0] h_reg;
    logic [VALUE_W-1:0] len_mix_reg;

    // output register
    logic               out_valid_reg;
    logic [5:0]         out_index_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_end_reg;
    logic               out_status_reg;

    logic [NG_W-1:0]       eff_n;
    logic [SLOT_CNT_W-1:0] eff_slots;
    logic                  in_take;
    logic                  out_take;
    logic                  out_load;
    logic [NG_W-1:0]       seen_base;
    logic [NG_W-1:0]       seen_next;
    logic [WIN_W-1:0]      window_next;
    logic                  last_slot;

    logic               mul_start;
    logic [VALUE_W-1:0] mul_op;
    logic               mul_done;
    logic [VALUE_W-1:0] mul_prod;

    logic               ram_wr_en;
    logic [SLOT_W-1:0]  ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;
    logic [VALUE_W-1:0] sig_cur;

    // out of range register values are clamped
    always_comb
    begin
        if (ngram_len_reg == 4'd0)
            eff_n = NG_W'(1);
        else if (int'(ngram_len_reg) > MAX_NGRAM)
            eff_n = NG_W'(MAX_NGRAM);
        else
            eff_n = NG_W'(ngram_len_reg);

        if (hashes_used_reg == 7'd0)
            eff_slots = SLOT_CNT_W'(1);
        else if (int'(hashes_used_reg) > NUM_SLOTS)
            eff_slots = SLOT_CNT_W'(NUM_SLOTS);
        else
            eff_slots = SLOT_CNT_W'(hashes_used_reg);
    end

    assign in_take  = token_ch.valid && token_ch.ready;
    assign out_take = slot_ch.valid && slot_ch.ready;

    // token count restarts on first, saturates at the window depth
    assign seen_base   = token_ch.first ? '0 : tokens_seen_reg;
    assign seen_next   = (int'(seen_base) < MAX_NGRAM) ? seen_base + NG_W'(1) : seen_base;
    // newest token enters at the top word, oldest sits in the low word
    assign window_next = (window_reg >> TOKEN_W)
                       | (WIN_W'(token_ch.token) << (WIN_W - TOKEN_W));

    assign last_slot = (SLOT_CNT_W'(slot_reg) + SLOT_CNT_W'(1)) == eff_slots;

    // slot not yet written since the last clear reads as all ones
    assign sig_cur = valid_reg[slot_reg] ? ram_rd_data : '1;

    assign out_load = (state_reg == S_RD_LOAD) && (!out_valid_reg || slot_ch.ready);

    // operand and start for the shared multiplier
    always_comb
    begin
        mul_start = 1'b0;
        mul_op    = h_reg;
        case (state_reg)
            S_DISPATCH:
            begin
                mul_start = 1'b1;
                if (pair_cnt_reg != '0)
                    mul_op = work_reg[63:0];
                else if (eff_n[0])
                    mul_op = h_reg ^ {32'b0, work_reg[31:0]};
                else
                    mul_op = xor_shift(h_reg);
            end
            S_MUL_K1:
            begin
                mul_start = mul_done;
                mul_op    = xor_shift(mul_prod);
            end
            S_MUL_K2:
            begin
                mul_start = mul_done;
                mul_op    = h_reg ^ mul_prod;
            end
            S_MUL_HT:
            begin
                mul_start = mul_done;
                mul_op    = xor_shift(mul_prod);
            end
            default: ;
        endcase
    end

    mhs_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_op),
        .done    (mul_done),
        .product (mul_prod)
    );

    // an unwritten slot always takes the hash, so its valid flag never
    // points at stale ram contents
    assign ram_wr_en   = (state_reg == S_UPDATE)
                       && (!valid_reg[slot_reg] || (h_reg < sig_cur));
    assign ram_rd_addr = slot_reg;

    mhs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_SLOTS)
    ) u_sig_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (h_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // configuration registers, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg   <= HASH_SEED_RST;
            hashes_used_reg <= HASHES_USED_RST;
            ngram_len_reg   <= NGRAM_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HASH_SEED:   hash_seed_reg   <= cfg_data;
                CFG_HASHES_USED: hashes_used_reg <= cfg_data[6:0];
                CFG_NGRAM_LEN:   ngram_len_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tokens_seen_reg <= '0;
            final_reg       <= 1'b0;
            slot_reg        <= '0;
            pair_cnt_reg    <= '0;
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        if (token_ch.first)
                            valid_reg <= '0;
                        tokens_seen_reg <= seen_next;
                        final_reg       <= token_ch.final_req;
                        slot_reg        <= '0;
                        if (seen_next >= eff_n)
                            state_reg <= S_SLOT;
                        else if (token_ch.final_req)
                            state_reg <= S_RD_ADDR;
                    end
                end
                S_SLOT:
                begin
                    pair_cnt_reg <= eff_n >> 1;
                    state_reg    <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    if (pair_cnt_reg != '0)
                    begin
                        pair_cnt_reg <= pair_cnt_reg - NG_W'(1);
                        state_reg    <= S_MUL_K1;
                    end
                    else if (eff_n[0])
                        state_reg <= S_MUL_HT;
                    else
                        state_reg <= S_MUL_F;
                end
                S_MUL_K1:
                    if (mul_done) state_reg <= S_MUL_K2;
                S_MUL_K2:
                    if (mul_done) state_reg <= S_MUL_HP;
                S_MUL_HP:
                    if (mul_done) state_reg <= S_DISPATCH;
                S_MUL_HT:
                    if (mul_done) state_reg <= S_MUL_F;
                S_MUL_F:
                    if (mul_done) state_reg <= S_UPDATE;
                S_UPDATE:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    if (last_slot)
                    begin
                        slot_reg  <= '0;
                        state_reg <= final_reg ? S_RD_ADDR : S_IDLE;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + SLOT_W'(1);
                        state_reg <= S_SLOT;
                    end
                end
                S_RD_ADDR:
                    state_reg <= S_RD_LOAD;
                S_RD_LOAD:
                begin
                    if (out_load)
                    begin
                        if (last_slot)
                        begin
                            slot_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            slot_reg  <= slot_reg + SLOT_W'(1);
                            state_reg <= S_RD_ADDR;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            window_reg  <= window_next;
            // oldest token of the n-gram moves down to the low word
            shingle_reg <= window_next >> (TOKEN_W * (MAX_NGRAM - int'(eff_n)));
            len_mix_reg <= (MIX_MUL * VALUE_W'(eff_n)) << 2;
        end

        case (state_reg)
            S_SLOT:
            begin
                h_reg    <= {32'b0, hash_seed_reg + 32'(slot_reg)} ^ len_mix_reg;
                work_reg <= WORK_W'(shingle_reg);
            end
            S_DISPATCH:
                if (pair_cnt_reg != '0) work_reg <= work_reg >> (2 * TOKEN_W);
            S_MUL_HP:
                if (mul_done) h_reg <= mul_prod;
            S_MUL_F:
                if (mul_done) h_reg <= xor_shift(mul_prod);
            default: ;
        endcase

        if (out_load)
        begin
            out_index_reg  <= 6'(slot_reg);
            out_value_reg  <= sig_cur;
            out_end_reg    <= last_slot;
            out_status_reg <= tokens_seen_reg < eff_n;
        end
    end

    assign token_ch.ready     = (state_reg == S_IDLE);
    assign slot_ch.valid      = out_valid_reg;
    assign slot_ch.slot_index = out_index_reg;
    assign slot_ch.slot_value = out_value_reg;
    assign slot_ch.end_of_run = out_end_reg;
    assign slot_ch.status     = out_status_reg;

endmodule

/* hw/rtl/mhs_chk.sv */
// ---------------------------------------------------------------------------
// mhs_chk
// port level checks on the minhash signature block, bound to the top level
// ---------------------------------------------------------------------------
module mhs_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_final_req,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  out_slot_index,
    input logic [63:0] out_slot_value,
    input logic        out_end_of_run,
    input logic        out_status
);

    // stalled readout transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_slot_index)
            && $stable(out_slot_value) && $stable(out_end_of_run) && $stable(out_status))
        else $error("readout payload changed while stalled");

    // a token asking for readout keeps the block busy afterwards
    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_final_req |=> !in_ready)
        else $error("block idle right after a final token");

    // slots of one readout follow in order
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_end_of_run
            |=> !out_valid || out_slot_index == 6'($past(out_slot_index) + 6'd1))
        else $error("readout slot out of order");

    // a new readout starts at slot zero
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_end_of_run |=> !out_valid || out_slot_index == 6'd0)
        else $error("readout did not restart at slot zero");

endmodule

bind minhash_ngram_signature_top mhs_chk u_mhs_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (token_ch.valid),
    .in_ready       (token_ch.ready),
    .in_final_req   (token_ch.final_req),
    .out_valid      (slot_ch.valid),
    .out_ready      (slot_ch.ready),
    .out_slot_index (slot_ch.slot_index),
    .out_slot_value (slot_ch.slot_value),
    .out_end_of_run (slot_ch.end_of_run),
    .out_status     (slot_ch.status)
);
